// ===== sv/lmns_pkg.sv =====
`timescale 1ns / 1ps

package lmns_pkg;

  // Digit and frame geometry.
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned SAT_W    = 14;
  localparam int unsigned ROWS     = 8;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned PANEL_W  = 8;
  localparam int unsigned WORD_W   = 2 * PANEL_W;
  localparam int unsigned BANKS    = 2;
  localparam int unsigned BANK_W   = $clog2(BANKS);
  localparam int unsigned ADDR_W   = BANK_W + ROW_W;
  localparam int unsigned DEPTH    = BANKS * ROWS;
  localparam int unsigned STEP_W   = 2 * ROW_W;

  // Saturation limit for the displayed number.
  localparam logic [VALUE_W-1:0] SAT_MAX = 16'd9999;

  // Reciprocal constants: q = (x * RECIP) >> SHIFT for the stated input range.
  localparam int unsigned PROD_W       = 27;
  localparam logic [13:0] RECIP_1000   = 14'd8389;
  localparam int unsigned SHIFT_1000   = 23;
  localparam logic [5:0]  RECIP_100    = 6'd41;
  localparam int unsigned SHIFT_100    = 12;
  localparam logic [7:0]  RECIP_10     = 8'd205;
  localparam int unsigned SHIFT_10     = 11;
  localparam int unsigned REM_W        = 10;

  localparam logic [REM_W-1:0] K1000 = 10'd1000;
  localparam logic [REM_W-1:0] K100  = 10'd100;
  localparam logic [REM_W-1:0] K10   = 10'd10;

  // Column position map, indexed by shift step.
  localparam logic [ROW_W-1:0] POSMAP [ROWS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd6, 3'd5, 3'd4
  };

  // Write request from the converter into the frame buffer.
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  // Read request and bank release from the scanner.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              release_bank;
  } rd_req_t;

  // Font row of one digit; rows are 4 bits wide.
  function automatic logic [DIGIT_W-1:0] font_row(input logic [DIGIT_W-1:0] digit,
                                                  input logic [ROW_W-1:0] row);
    logic [DIGIT_W*ROWS-1:0] glyph;
    case (digit)
      4'd0:    glyph = {4'hf, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'hf, 4'h0};
      4'd1:    glyph = {4'h6, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h7, 4'h0};
      4'd2:    glyph = {4'hf, 4'h1, 4'h1, 4'hf, 4'h8, 4'h8, 4'hf, 4'h0};
      4'd3:    glyph = {4'hf, 4'h1, 4'h1, 4'hf, 4'h1, 4'h1, 4'hf, 4'h0};
      4'd4:    glyph = {4'h9, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'h1, 4'h0};
      4'd5:    glyph = {4'hf, 4'h8, 4'h8, 4'hf, 4'h1, 4'h1, 4'hf, 4'h0};
      4'd6:    glyph = {4'hf, 4'h8, 4'h8, 4'hf, 4'h9, 4'h9, 4'hf, 4'h0};
      4'd7:    glyph = {4'hf, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0};
      4'd8:    glyph = {4'hf, 4'h9, 4'h9, 4'hf, 4'h9, 4'h9, 4'hf, 4'h0};
      4'd9:    glyph = {4'hf, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'h1, 4'h0};
      default: glyph = '0;
    endcase
    return glyph[row*DIGIT_W +: DIGIT_W];
  endfunction

endpackage

// ===== sv/lmns_convert.sv =====
`timescale 1ns / 1ps

module lmns_convert (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [lmns_pkg::VALUE_W-1:0]       value,
  output logic                               idle,
  output logic                               done,
  output lmns_pkg::wr_req_t                  wr
);

  typedef enum logic [2:0] {
    S_IDLE, S_TH, S_HU, S_HP, S_TE, S_TP, S_ON, S_WR
  } state_t;

  state_t                                state_r, state_nxt;
  logic [lmns_pkg::SAT_W-1:0]            v_r, v_nxt;
  logic [lmns_pkg::PROD_W-1:0]           prod_r, prod_nxt;
  logic [lmns_pkg::REM_W-1:0]            rem_r, rem_nxt;
  logic [lmns_pkg::DIGIT_W-1:0]          th_r, th_nxt;
  logic [lmns_pkg::DIGIT_W-1:0]          hu_r, hu_nxt;
  logic [lmns_pkg::DIGIT_W-1:0]          te_r, te_nxt;
  logic [lmns_pkg::DIGIT_W-1:0]          on_r, on_nxt;
  logic [lmns_pkg::ROW_W-1:0]            row_r, row_nxt;
  logic [lmns_pkg::DIGIT_W-1:0]          quot;
  logic                                  show_th, show_hu, show_te;
  logic [lmns_pkg::DIGIT_W-1:0]          g_th, g_hu, g_te, g_on;

  // Blanking of leading zero digits.
  assign show_th = (th_r != '0);
  assign show_hu = show_th || (hu_r != '0);
  assign show_te = show_hu || (te_r != '0);

  // Font rows for the row being written.
  always_comb begin
    g_on = lmns_pkg::font_row(on_r, row_r);
    g_te = show_te ? lmns_pkg::font_row(te_r, row_r) : '0;
    g_hu = show_hu ? lmns_pkg::font_row(hu_r, row_r) : '0;
    g_th = show_th ? lmns_pkg::font_row(th_r, row_r) : '0;
  end

  // Sequencer: saturate, split into digits through reciprocal multiplies,
  // then write the eight rows of the frame.
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    th_nxt    = th_r;
    hu_nxt    = hu_r;
    te_nxt    = te_r;
    on_nxt    = on_r;
    row_nxt   = row_r;
    quot      = '0;
    done      = 1'b0;
    wr.en     = 1'b0;
    wr.row    = row_r;
    wr.data   = {g_th, g_hu, g_te, g_on};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          v_nxt = (value > lmns_pkg::SAT_MAX) ? lmns_pkg::SAT_MAX[lmns_pkg::SAT_W-1:0]
                                              : value[lmns_pkg::SAT_W-1:0];
          state_nxt = S_TH;
        end
      end
      S_TH: begin
        prod_nxt  = lmns_pkg::PROD_W'(v_r * lmns_pkg::RECIP_1000);
        state_nxt = S_HU;
      end
      S_HU: begin
        quot      = prod_r[lmns_pkg::SHIFT_1000 +: lmns_pkg::DIGIT_W];
        th_nxt    = quot;
        rem_nxt   = lmns_pkg::REM_W'(v_r - lmns_pkg::SAT_W'(quot * lmns_pkg::K1000));
        state_nxt = S_HP;
      end
      S_HP: begin
        prod_nxt  = lmns_pkg::PROD_W'(rem_r * lmns_pkg::RECIP_100);
        state_nxt = S_TE;
      end
      S_TE: begin
        quot      = prod_r[lmns_pkg::SHIFT_100 +: lmns_pkg::DIGIT_W];
        hu_nxt    = quot;
        rem_nxt   = rem_r - lmns_pkg::REM_W'(quot * lmns_pkg::K100);
        state_nxt = S_TP;
      end
      S_TP: begin
        prod_nxt  = lmns_pkg::PROD_W'(rem_r * lmns_pkg::RECIP_10);
        state_nxt = S_ON;
      end
      S_ON: begin
        quot      = prod_r[lmns_pkg::SHIFT_10 +: lmns_pkg::DIGIT_W];
        te_nxt    = quot;
        on_nxt    = lmns_pkg::DIGIT_W'(rem_r - lmns_pkg::REM_W'(quot * lmns_pkg::K10));
        row_nxt   = '0;
        state_nxt = S_WR;
      end
      S_WR: begin
        wr.en   = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r == lmns_pkg::ROW_W'(lmns_pkg::ROWS - 1)) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r    <= v_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    th_r   <= th_nxt;
    hu_r   <= hu_nxt;
    te_r   <= te_nxt;
    on_r   <= on_nxt;
    row_r  <= row_nxt;
  end

endmodule

// ===== sv/lmns_scan.sv =====
`timescale 1ns / 1ps

module lmns_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lmns_pkg::BANKS-1:0]          bank_full,
  input  logic [lmns_pkg::WORD_W-1:0]         rdata,
  output lmns_pkg::rd_req_t                   rd,
  output logic                                out_valid,
  output logic [lmns_pkg::ROW_W-1:0]          out_column_index,
  output logic [lmns_pkg::ROW_W-1:0]          out_shift_position,
  output logic                                out_column_select,
  output logic                                out_panel_a_bit,
  output logic                                out_panel_b_bit,
  output logic                                out_column_done,
  output logic                                out_last
);

  logic [lmns_pkg::BANK_W-1:0]  rb_r, rb_nxt;
  logic [lmns_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic                         vld_q_r;
  logic [lmns_pkg::STEP_W-1:0]  step_q_r;
  logic [lmns_pkg::ROW_W-1:0]   col_q, pos_q;
  logic                         frame_end;

  // Read the row of the current column every step while the bank holds a frame.
  assign frame_end       = (cnt_r == {lmns_pkg::STEP_W{1'b1}});
  assign rd.en           = bank_full[rb_r];
  assign rd.addr         = {rb_r, cnt_r[lmns_pkg::STEP_W-1 -: lmns_pkg::ROW_W]};
  assign rd.release_bank = rd.en && frame_end;

  always_comb begin
    cnt_nxt = cnt_r;
    rb_nxt  = rb_r;
    if (rd.en) begin
      cnt_nxt = cnt_r + 1'b1;
      if (frame_end) begin
        rb_nxt = rb_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r    <= '0;
      cnt_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      rb_r    <= rb_nxt;
      cnt_r   <= cnt_nxt;
      vld_q_r <= rd.en;
    end
    step_q_r <= cnt_r;
  end

  // Result word formed from the row read in the previous cycle.
  assign col_q = step_q_r[lmns_pkg::STEP_W-1 -: lmns_pkg::ROW_W];
  assign pos_q = step_q_r[lmns_pkg::ROW_W-1:0];

  assign out_valid          = vld_q_r;
  assign out_column_index   = col_q;
  assign out_shift_position = pos_q;
  assign out_column_select  = (lmns_pkg::POSMAP[pos_q] == col_q);
  assign out_panel_a_bit    = rdata[{1'b0, pos_q}];
  assign out_panel_b_bit    = rdata[{1'b1, pos_q}];
  assign out_column_done    = (pos_q == {lmns_pkg::ROW_W{1'b1}});
  assign out_last           = (step_q_r == {lmns_pkg::STEP_W{1'b1}});

endmodule

// ===== sv/led_matrix_number_scanner_unit.sv =====
`timescale 1ns / 1ps
// A frame's first word leaves once the converter has filled its bank and the scanner has
// read its first row. 64 words per number, one per cycle in a frame; new numbers are paced
// by the scanner reading one frame-buffer row per word through its single read port.
// A two-bank frame buffer lets the next number be converted while a frame is shifted out.
// Reset (synchronous, active low) empties both banks and idles the converter and scanner.
// The receiver cannot stall: each word is on the out_ ports for exactly one cycle.
module led_matrix_number_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_column_index,
  output logic [2:0]  out_shift_position,
  output logic        out_column_select,
  output logic        out_panel_a_bit,
  output logic        out_panel_b_bit,
  output logic        out_column_done,
  output logic        out_last
);

  logic                               conv_idle, conv_done, accept;
  lmns_pkg::wr_req_t                  wr;
  lmns_pkg::rd_req_t                  rd;
  logic [lmns_pkg::BANKS-1:0]         full_r, full_nxt;
  logic [lmns_pkg::BANK_W-1:0]        wb_r, wb_nxt;
  logic [lmns_pkg::WORD_W-1:0]        mem [lmns_pkg::DEPTH];
  logic [lmns_pkg::WORD_W-1:0]        rdata_r;

  // A number is taken when the converter is free and its target bank is empty.
  assign busy   = !conv_idle || full_r[wb_r];
  assign accept = start && !busy;

  lmns_convert u_convert (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .value  (in_value),
    .idle   (conv_idle),
    .done   (conv_done),
    .wr     (wr)
  );

  // Bank ownership: the converter fills one bank, the scanner drains the other.
  always_comb begin
    full_nxt = full_r;
    wb_nxt   = wb_r;
    if (conv_done) begin
      full_nxt[wb_r] = 1'b1;
      wb_nxt         = wb_r + 1'b1;
    end
    if (rd.release_bank) begin
      full_nxt[rd.addr[lmns_pkg::ADDR_W-1 -: lmns_pkg::BANK_W]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      wb_r   <= '0;
    end else begin
      full_r <= full_nxt;
      wb_r   <= wb_nxt;
    end
  end

  // Frame buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wb_r, wr.row}] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  lmns_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .bank_full          (full_r),
    .rdata              (rdata_r),
    .rd                 (rd),
    .out_valid          (out_valid),
    .out_column_index   (out_column_index),
    .out_shift_position (out_shift_position),
    .out_column_select  (out_column_select),
    .out_panel_a_bit    (out_panel_a_bit),
    .out_panel_b_bit    (out_panel_b_bit),
    .out_column_done    (out_column_done),
    .out_last           (out_last)
  );

endmodule

// ===== tb/led_matrix_number_scanner_unit_test.sv =====
`timescale 1ns / 1ps

module led_matrix_number_scanner_unit_test;

  // One shifted word of a display frame, as seen on the out_ ports.
  typedef struct packed {
    logic [2:0] column_index;
    logic [2:0] shift_position;
    logic       column_select;
    logic       panel_a_bit;
    logic       panel_b_bit;
    logic       column_done;
    logic       last;
  } scan_word_t;

  // A directed number, with the panel rows typed in where they are obvious.
  // Rows are packed with column 7 in the top byte and column 0 in the bottom byte.
  typedef struct packed {
    logic [15:0] value;
    logic        typed;
    logic [63:0] rows_a;
    logic [63:0] rows_b;
  } number_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 208;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [63:0] ROWS_ZERO    = 64'h0f09_0909_0909_0f00;
  localparam logic [63:0] ROWS_ONE     = 64'h0602_0202_0202_0700;
  localparam logic [63:0] ROWS_NINES   = 64'hff99_99ff_1111_1100;
  localparam logic [63:0] ROWS_BLANK   = 64'h0;

  localparam number_row_t DIRECTED_NUMBERS [NUM_DIRECTED] = '{
    '{16'd0,     1'b1, ROWS_ZERO,  ROWS_BLANK},
    '{16'd1,     1'b1, ROWS_ONE,   ROWS_BLANK},
    '{16'd9,     1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd10,    1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd99,    1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd100,   1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd101,   1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd999,   1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd1000,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd1001,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd1010,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd1100,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd2345,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd6789,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd4560,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd8000,  1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd7,     1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd9999,  1'b1, ROWS_NINES, ROWS_NINES},
    '{16'd10000, 1'b1, ROWS_NINES, ROWS_NINES},
    '{16'd65535, 1'b1, ROWS_NINES, ROWS_NINES},
    '{16'd32768, 1'b0, ROWS_BLANK, ROWS_BLANK},
    '{16'd12345, 1'b0, ROWS_BLANK, ROWS_BLANK}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [15:0] in_value = 16'd0;
  logic        busy;
  logic        out_valid;
  logic [2:0]  out_column_index;
  logic [2:0]  out_shift_position;
  logic        out_column_select;
  logic        out_panel_a_bit;
  logic        out_panel_b_bit;
  logic        out_column_done;
  logic        out_last;

  scan_word_t  frame_words [$];
  scan_word_t  got_word;
  scan_word_t  want_word;
  bit          failed = 1'b0;

  led_matrix_number_scanner_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_column_index   (out_column_index),
    .out_shift_position (out_shift_position),
    .out_column_select  (out_column_select),
    .out_panel_a_bit    (out_panel_a_bit),
    .out_panel_b_bit    (out_panel_b_bit),
    .out_column_done    (out_column_done),
    .out_last           (out_last)
  );

  always #1 clk = ~clk;

  // Font rows of one digit, column 7 in the top nibble.
  function automatic logic [31:0] glyph_rows(input int digit);
    case (digit)
      0:       return 32'hf999_99f0;
      1:       return 32'h6222_2270;
      2:       return 32'hf11f_88f0;
      3:       return 32'hf11f_11f0;
      4:       return 32'h999f_1110;
      5:       return 32'hf88f_11f0;
      6:       return 32'hf88f_99f0;
      7:       return 32'hf111_1110;
      8:       return 32'hf99f_99f0;
      9:       return 32'hf99f_1110;
      default: return 32'h0;
    endcase
  endfunction

  // Queue the 64 words of one frame, column by column, from the two panels' rows.
  task automatic push_frame(input logic [63:0] rows_a, input logic [63:0] rows_b);
    scan_word_t word;
    int         mapped;
    for (int c = 0; c < 8; c++) begin
      for (int d = 0; d < 8; d++) begin
        // The lower four steps map straight through; the upper four run backward.
        mapped = (d < 4) ? d : 11 - d;
        word.column_index   = c[2:0];
        word.shift_position = d[2:0];
        word.column_select  = (mapped == c);
        word.panel_a_bit    = rows_a[c*8 + d];
        word.panel_b_bit    = rows_b[c*8 + d];
        word.column_done    = (d == 7);
        word.last           = (c == 7) && (d == 7);
        frame_words.push_back(word);
      end
    end
  endtask

  // Clip a number to 9999, split it into digits, blank the leading zeros and queue the frame.
  task automatic predict_frame(input logic [15:0] value);
    int          clipped;
    int          thou;
    int          hund;
    int          tens;
    int          ones;
    logic [31:0] thou_g;
    logic [31:0] hund_g;
    logic [31:0] tens_g;
    logic [31:0] ones_g;
    logic [63:0] rows_a;
    logic [63:0] rows_b;
    clipped = (value > 16'd9999) ? 9999 : int'(value);
    thou = clipped / 1000;
    hund = (clipped / 100) % 10;
    tens = (clipped / 10) % 10;
    ones = clipped % 10;
    thou_g = (thou != 0) ? glyph_rows(thou) : 32'h0;
    hund_g = (thou != 0 || hund != 0) ? glyph_rows(hund) : 32'h0;
    tens_g = (thou != 0 || hund != 0 || tens != 0) ? glyph_rows(tens) : 32'h0;
    ones_g = glyph_rows(ones);
    for (int c = 0; c < 8; c++) begin
      rows_a[c*8 +: 8] = {tens_g[c*4 +: 4], ones_g[c*4 +: 4]};
      rows_b[c*8 +: 8] = {thou_g[c*4 +: 4], hund_g[c*4 +: 4]};
    end
    push_frame(rows_a, rows_b);
  endtask

  // Offer one number, with an optional idle burst first, and wait until it is taken.
  task automatic show_number(input logic [15:0] value, input bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Compare every shifted word with the oldest expected word.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word = '{out_column_index, out_shift_position, out_column_select,
                   out_panel_a_bit, out_panel_b_bit, out_column_done, out_last};
      if (frame_words.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected word: expected none, got %h", $realtime, got_word);
      end else begin
        want_word = frame_words.pop_front();
        if (got_word !== want_word) begin
          failed = 1'b1;
          $display("%0t: expected col %0d step %0d sel %b a %b b %b done %b last %b",
                   $realtime, want_word.column_index, want_word.shift_position,
                   want_word.column_select, want_word.panel_a_bit,
                   want_word.panel_b_bit, want_word.column_done, want_word.last);
          $display("%0t: actual   col %0d step %0d sel %b a %b b %b done %b last %b",
                   $realtime, got_word.column_index, got_word.shift_position,
                   got_word.column_select, got_word.panel_a_bit,
                   got_word.panel_b_bit, got_word.column_done, got_word.last);
        end
      end
    end
  end

  // Main sequence: reset, directed numbers, random numbers, drain.
  initial begin
    logic [15:0] value;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed numbers: extremes, blanking cases and saturation.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      show_number(DIRECTED_NUMBERS[i].value, 1'b1);
      if (DIRECTED_NUMBERS[i].typed) begin
        push_frame(DIRECTED_NUMBERS[i].rows_a, DIRECTED_NUMBERS[i].rows_b);
      end else begin
        predict_frame(DIRECTED_NUMBERS[i].value);
      end
    end

    // Random numbers, weighted toward the four-digit range and toward zero digits.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0:       value = 16'($urandom_range(0, 9));
        1:       value = 16'($urandom_range(10, 99));
        2:       value = 16'($urandom_range(100, 999));
        3:       value = 16'($urandom_range(0, 99) * 100);
        4:       value = 16'($urandom_range(10000, 65535));
        5:       value = 16'($urandom);
        default: value = 16'($urandom_range(1000, 9999));
      endcase
      show_number(value, !((i >= 100 && i < 130) || i >= 170));
      predict_frame(value);
    end
    start <= 1'b0;

    // Let the last frames drain, then watch for stray words.
    while (frame_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && frame_words.size() == 0) begin
      $display("[led_matrix_number_scanner_unit] OK");
    end else begin
      $display("[led_matrix_number_scanner_unit] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a frame that never ends.
  initial begin
    #2000000;
    $display("[led_matrix_number_scanner_unit] ERROR");
    $finish;
  end

endmodule
